// File: rtl/xs128_pkg.sv
// xs128_pkg: shared types and constants for the xorshift128 generator core
// holds operation codes, reset words, shift amounts and the sequencer states
// no dependencies
package xs128_pkg;

	// operation codes carried in the input item
	localparam logic [2:0] OP_SEED   = 3'd0;
	localparam logic [2:0] OP_LOAD   = 3'd1;
	localparam logic [2:0] OP_NEXT32 = 3'd2;
	localparam logic [2:0] OP_NEXT64 = 3'd3;
	localparam logic [2:0] OP_READ   = 3'd4;

	// seeding multiplier and state reset words
	localparam logic [31:0] SEED_MULT = 32'h6C07_8965;
	localparam logic [31:0] RESET_A   = 32'h0000_0001;
	localparam logic [31:0] RESET_B   = 32'h6C07_8967;
	localparam logic [31:0] RESET_C   = 32'h714A_CB41;
	localparam logic [31:0] RESET_D   = 32'h4807_7044;

	// shift amounts
	localparam int unsigned MIX_SHIFT = 30;
	localparam int unsigned SHL_A     = 11;
	localparam int unsigned SHR_T     = 8;
	localparam int unsigned SHR_D     = 19;

	// packed payload widths
	localparam int unsigned IN_BITS  = 195;
	localparam int unsigned IN_BYTES = (IN_BITS + 7) / 8;
	localparam int unsigned OUT_BITS = 192;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEED,
		ST_STEP,
		ST_DONE
	} state_t;

endpackage

// File: rtl/xorshift128_random_generator_core.sv
// xorshift128_random_generator_core: top level with sequencer and state words
// depends on xs128_pkg, xs128_chain_unit, xs128_step_unit
//
// Xorshift128 generator with four 32-bit state words. Each input item is one
// operation (seed, load, next 32-bit, next 64-bit, read) and yields exactly one
// result item holding the value and the four state words after the operation.
// The seeding chain passes four times through one shared 32-bit multiply-add
// unit and generation passes once per step through one shared shift-xor unit.
// The input side is ready only while the sequencer is idle; a finished result
// waits in an output register, so the next item can be accepted before the
// previous result is taken.
module xorshift128_random_generator_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// operation[2:0], seed_value[66:3], load_word0[98:67], load_word1[130:99],
	// load_word2[162:131], load_word3[194:163], zero fill above
	input  logic [xs128_pkg::IN_BYTES*8-1:0]    s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// random_value[63:0], context_word0[95:64], context_word1[127:96],
	// context_word2[159:128], context_word3[191:160]
	output logic [xs128_pkg::OUT_BITS-1:0]      m_tdata
);

	xs128_pkg::state_t state_q, state_d;

	logic [2:0]  op_q;
	logic [63:0] seed_q;
	logic [1:0]  count_q;
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [63:0] value_q;
	logic        out_valid_q;
	logic [xs128_pkg::OUT_BITS-1:0] out_data_q;

	logic [2:0]  in_op;
	logic [63:0] in_seed;
	logic [31:0] in_w0, in_w1, in_w2, in_w3;
	logic        accept;
	logic        out_load;
	logic        last_iter;
	logic [31:0] chain_word;
	logic [31:0] step_word;

	// unpack the input item
	assign in_op   = s_tdata[2:0];
	assign in_seed = s_tdata[66:3];
	assign in_w0   = s_tdata[98:67];
	assign in_w1   = s_tdata[130:99];
	assign in_w2   = s_tdata[162:131];
	assign in_w3   = s_tdata[194:163];

	assign s_tready = (state_q == xs128_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// shared arithmetic units
	xs128_chain_unit u_chain (
		.first (count_q == 2'd0),
		.seed  (seed_q),
		.prev  (d_q),
		.index (count_q),
		.word  (chain_word)
	);

	xs128_step_unit u_step (
		.word_a   (a_q),
		.word_d   (d_q),
		.word_new (step_word)
	);

	// next state and output register load
	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		last_iter = 1'b0;
		unique case (state_q)
			xs128_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (in_op)
						xs128_pkg::OP_SEED:   state_d = xs128_pkg::ST_SEED;
						xs128_pkg::OP_NEXT32,
						xs128_pkg::OP_NEXT64: state_d = xs128_pkg::ST_STEP;
						default:              state_d = xs128_pkg::ST_DONE;
					endcase
				end
			end
			xs128_pkg::ST_SEED: begin
				last_iter = (count_q == 2'd3);
				if (last_iter) begin
					state_d = xs128_pkg::ST_DONE;
				end
			end
			xs128_pkg::ST_STEP: begin
				last_iter = (op_q == xs128_pkg::OP_NEXT32) || (count_q == 2'd1);
				if (last_iter) begin
					state_d = xs128_pkg::ST_DONE;
				end
			end
			xs128_pkg::ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = xs128_pkg::ST_IDLE;
				end
			end
			default: state_d = xs128_pkg::ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= xs128_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// generator state words and iteration counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q     <= xs128_pkg::RESET_A;
			b_q     <= xs128_pkg::RESET_B;
			c_q     <= xs128_pkg::RESET_C;
			d_q     <= xs128_pkg::RESET_D;
			count_q <= 2'd0;
		end else begin
			unique case (state_q)
				xs128_pkg::ST_IDLE: begin
					count_q <= 2'd0;
					if (accept && in_op == xs128_pkg::OP_LOAD) begin
						if ((in_w0 | in_w1 | in_w2 | in_w3) != 32'd0) begin
							a_q <= in_w0;
							b_q <= in_w1;
							c_q <= in_w2;
							d_q <= in_w3;
						end else begin
							a_q <= xs128_pkg::RESET_A;
							b_q <= xs128_pkg::RESET_B;
							c_q <= xs128_pkg::RESET_C;
							d_q <= xs128_pkg::RESET_D;
						end
					end
				end
				xs128_pkg::ST_SEED: begin
					// chain words enter at d and move down to a
					a_q     <= b_q;
					b_q     <= c_q;
					c_q     <= d_q;
					d_q     <= chain_word;
					count_q <= count_q + 2'd1;
				end
				xs128_pkg::ST_STEP: begin
					a_q     <= b_q;
					b_q     <= c_q;
					c_q     <= d_q;
					d_q     <= step_word;
					count_q <= count_q + 2'd1;
				end
				default: count_q <= 2'd0;
			endcase
		end
	end

	// captured item fields and generated value
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= in_op;
			seed_q  <= in_seed;
			value_q <= 64'd0;
		end else if (state_q == xs128_pkg::ST_STEP) begin
			value_q <= {value_q[31:0], step_word};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {d_q, c_q, b_q, a_q, value_q};
		end
	end

endmodule

// File: rtl/xs128_chain_unit.sv
// xs128_chain_unit: one seeding chain link, mult * (p ^ (p >> 30)) + k mod 2^32
// first link mixes the 64-bit seed, later links mix the previous word
// depends on xs128_pkg
module xs128_chain_unit (
	input  logic        first,
	input  logic [63:0] seed,
	input  logic [31:0] prev,
	input  logic [1:0]  index,
	output logic [31:0] word
);

	logic [63:0] seed_mix;
	logic [31:0] mixed;
	logic [31:0] k;

	// fold the operand and multiply, truncated to 32 bits
	always_comb begin
		seed_mix = seed ^ (seed >> xs128_pkg::MIX_SHIFT);
		if (first) begin
			mixed = seed_mix[31:0];
		end else begin
			mixed = prev ^ (prev >> xs128_pkg::MIX_SHIFT);
		end
		k    = {30'd0, index} + 32'd1;
		word = xs128_pkg::SEED_MULT * mixed + k;
	end

endmodule

// File: rtl/xs128_step_unit.sv
// xs128_step_unit: one xorshift128 step, new word from word a and word d
// shift-xor network only, the caller shifts the state words
// depends on xs128_pkg
module xs128_step_unit (
	input  logic [31:0] word_a,
	input  logic [31:0] word_d,
	output logic [31:0] word_new
);

	logic [31:0] t;

	// t = a ^ (a << 11), w = t ^ (t >> 8) ^ d ^ (d >> 19)
	always_comb begin
		t        = word_a ^ (word_a << xs128_pkg::SHL_A);
		word_new = t ^ (t >> xs128_pkg::SHR_T) ^ word_d ^ (word_d >> xs128_pkg::SHR_D);
	end

endmodule

// File: bench/tb_xorshift128_random_generator_core.sv
`timescale 1ns / 1ps
// tb_xorshift128_random_generator_core: self-checking bench for the xorshift128 core
// depends on xs128_pkg and xorshift128_random_generator_core; a tracker class predicts results
module tb_xorshift128_random_generator_core;

	localparam int CLK_HALF       = 4;
	localparam int RESET_CYCLES   = 6;
	localparam int RANDOM_ITEMS   = 600;
	localparam int DRAIN_CYCLES   = 20;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REPORT_LIMIT   = 10;

	// input item, first field in the lowest bits
	typedef struct packed {
		logic [4:0]  fill;
		logic [31:0] load_word3;
		logic [31:0] load_word2;
		logic [31:0] load_word1;
		logic [31:0] load_word0;
		logic [63:0] seed_value;
		logic [2:0]  operation;
	} op_item_t;

	// result item, first field in the lowest bits
	typedef struct packed {
		logic [31:0] context_word3;
		logic [31:0] context_word2;
		logic [31:0] context_word1;
		logic [31:0] context_word0;
		logic [63:0] random_value;
	} result_t;

	// tracks generator state and the queue of predicted result items
	class prng_tracker_t;
		logic [31:0] word_a, word_b, word_c, word_d;
		result_t expected_results[$];
		int unsigned mismatches;

		function new();
			restore_defaults();
			mismatches = 0;
		endfunction

		function void restore_defaults();
			word_a = xs128_pkg::RESET_A;
			word_b = xs128_pkg::RESET_B;
			word_c = xs128_pkg::RESET_C;
			word_d = xs128_pkg::RESET_D;
		endfunction

		function logic [31:0] chain_word(logic [31:0] prev, logic [31:0] k);
			return xs128_pkg::SEED_MULT * (prev ^ (prev >> xs128_pkg::MIX_SHIFT)) + k;
		endfunction

		// one xorshift step, returns the new last word
		function logic [31:0] xorshift_step();
			logic [31:0] t, w;
			t = word_a ^ (word_a << xs128_pkg::SHL_A);
			w = t ^ (t >> xs128_pkg::SHR_T) ^ word_d
				^ (word_d >> xs128_pkg::SHR_D);
			word_a = word_b;
			word_b = word_c;
			word_c = word_d;
			word_d = w;
			return w;
		endfunction

		// predict the result of one accepted input item
		function void note_op(op_item_t item);
			result_t r;
			logic [63:0] mix64;
			logic [31:0] hi, lo;
			r.random_value = '0;
			case (item.operation)
				xs128_pkg::OP_SEED: begin
					mix64 = item.seed_value ^ (item.seed_value >> xs128_pkg::MIX_SHIFT);
					word_a = xs128_pkg::SEED_MULT * mix64[31:0] + 32'd1;
					word_b = chain_word(word_a, 32'd2);
					word_c = chain_word(word_b, 32'd3);
					word_d = chain_word(word_c, 32'd4);
				end
				xs128_pkg::OP_LOAD: begin
					if ((item.load_word0 | item.load_word1 | item.load_word2
						| item.load_word3) != 32'd0) begin
						word_a = item.load_word0;
						word_b = item.load_word1;
						word_c = item.load_word2;
						word_d = item.load_word3;
					end else begin
						restore_defaults();
					end
				end
				xs128_pkg::OP_NEXT32: begin
					lo = xorshift_step();
					r.random_value = {32'd0, lo};
				end
				xs128_pkg::OP_NEXT64: begin
					hi = xorshift_step();
					lo = xorshift_step();
					r.random_value = {hi, lo};
				end
				default: begin
				end
			endcase
			r.context_word0 = word_a;
			r.context_word1 = word_b;
			r.context_word2 = word_c;
			r.context_word3 = word_d;
			expected_results.push_back(r);
		endfunction

		function void report(string field, logic [63:0] want, logic [63:0] got);
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("%0t: mismatch in %s: expected %h, got %h",
					$time, field, want, got);
		endfunction

		// compare one result item with the oldest prediction
		function void check_result(result_t got);
			result_t want;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: result item with nothing expected: %h", $time, got);
				return;
			end
			want = expected_results.pop_front();
			if (got.random_value !== want.random_value)
				report("random_value", want.random_value, got.random_value);
			if (got.context_word0 !== want.context_word0)
				report("context_word0", 64'(want.context_word0), 64'(got.context_word0));
			if (got.context_word1 !== want.context_word1)
				report("context_word1", 64'(want.context_word1), 64'(got.context_word1));
			if (got.context_word2 !== want.context_word2)
				report("context_word2", 64'(want.context_word2), 64'(got.context_word2));
			if (got.context_word3 !== want.context_word3)
				report("context_word3", 64'(want.context_word3), 64'(got.context_word3));
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	// operation, seed_value, load_word0..load_word3, zero fill
	logic [xs128_pkg::IN_BYTES*8-1:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	// random_value, context_word0..context_word3
	logic [xs128_pkg::OUT_BITS-1:0]   m_tdata;

	prng_tracker_t tracker;
	bit quiet;
	int unsigned stall_left;

	xorshift128_random_generator_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// clock
	initial clk = 1'b0;
	always #(CLK_HALF) clk = ~clk;

	// idle length: mostly none or short, sometimes long
	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic op_item_t make_item(logic [2:0] op, logic [63:0] seed,
		logic [31:0] l0, logic [31:0] l1, logic [31:0] l2, logic [31:0] l3);
		op_item_t it;
		it.fill       = '0;
		it.operation  = op;
		it.seed_value = seed;
		it.load_word0 = l0;
		it.load_word1 = l1;
		it.load_word2 = l2;
		it.load_word3 = l3;
		return it;
	endfunction

	// random item: mostly generation, with seeds, loads, reads and unused codes
	function automatic op_item_t random_item();
		op_item_t it;
		int unsigned pick;
		it = make_item(xs128_pkg::OP_READ, {$urandom, $urandom},
			$urandom, $urandom, $urandom, $urandom);
		pick = $urandom_range(0, 99);
		if (pick < 30)
			it.operation = xs128_pkg::OP_NEXT32;
		else if (pick < 60)
			it.operation = xs128_pkg::OP_NEXT64;
		else if (pick < 70)
			it.operation = xs128_pkg::OP_SEED;
		else if (pick < 82)
			it.operation = xs128_pkg::OP_LOAD;
		else if (pick < 90)
			it.operation = xs128_pkg::OP_READ;
		else
			it.operation = 3'($urandom_range(5, 7));
		// small seeds now and then
		if (it.operation == xs128_pkg::OP_SEED && $urandom_range(0, 3) == 0)
			it.seed_value[63:32] = '0;
		// loads with some or all words zero
		if (it.operation == xs128_pkg::OP_LOAD) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				it.load_word0 = '0;
				it.load_word1 = '0;
				it.load_word2 = '0;
				it.load_word3 = '0;
			end else if (pick < 3) begin
				if ($urandom_range(0, 1)) it.load_word0 = '0;
				if ($urandom_range(0, 1)) it.load_word1 = '0;
				if ($urandom_range(0, 1)) it.load_word2 = '0;
				if ($urandom_range(0, 1)) it.load_word3 = '0;
			end
		end
		return it;
	endfunction

	// present one item at the falling edge and hold it until accepted
	task automatic send_op(input op_item_t item);
		int unsigned gap;
		gap = quiet ? 0 : gap_len();
		if (gap != 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  = item;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic wait_for_drain();
		s_tvalid = 1'b0;
		while (tracker.pending() != 0) @(negedge clk);
	endtask

	// receiver with random stalls
	always @(negedge clk) begin
		if (stall_left != 0) begin
			m_tready = 1'b0;
			stall_left--;
		end else begin
			m_tready = 1'b1;
			if (!quiet && $urandom_range(0, 3) == 0)
				stall_left = gap_len();
		end
	end

	// note accepted inputs, check accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				tracker.note_op(op_item_t'(s_tdata));
			if (m_tvalid && m_tready)
				tracker.check_result(result_t'(m_tdata));
		end
	end

	// watchdog on cycles without any handshake
	initial begin
		int unsigned idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("** xorshift128_random_generator_core: FAILED **");
		$finish;
	end

	// stimulus
	initial begin
		tracker    = new();
		quiet      = 1'b0;
		stall_left = 0;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		m_tready   = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset state, generation, seed extremes, load cases, unused codes
		send_op(make_item(xs128_pkg::OP_READ, '0, '0, '0, '0, '0));
		send_op(make_item(xs128_pkg::OP_NEXT32, '0, '0, '0, '0, '0));
		send_op(make_item(xs128_pkg::OP_NEXT64, '1, '1, '1, '1, '1));
		send_op(make_item(xs128_pkg::OP_SEED, 64'd0, '1, '1, '1, '1));
		send_op(make_item(xs128_pkg::OP_READ, '1, '1, '1, '1, '1));
		send_op(make_item(xs128_pkg::OP_SEED, '1, '0, '0, '0, '0));
		send_op(make_item(xs128_pkg::OP_NEXT64, '0, '0, '0, '0, '0));
		send_op(make_item(xs128_pkg::OP_SEED, 64'hFFFF_FFFF_0000_0000, '0, '0, '0, '0));
		send_op(make_item(xs128_pkg::OP_NEXT32, '0, '0, '0, '0, '0));
		// all-zero load restores the reset words
		send_op(make_item(xs128_pkg::OP_LOAD, '1, '0, '0, '0, '0));
		send_op(make_item(xs128_pkg::OP_NEXT32, '0, '0, '0, '0, '0));
		send_op(make_item(xs128_pkg::OP_LOAD, '0, '1, '1, '1, '1));
		send_op(make_item(xs128_pkg::OP_NEXT32, '1, '1, '1, '1, '1));
		send_op(make_item(xs128_pkg::OP_NEXT64, '0, '0, '0, '0, '0));
		send_op(make_item(xs128_pkg::OP_LOAD, '0, '0, '0, '0, 32'd1));
		send_op(make_item(xs128_pkg::OP_NEXT64, '0, '0, '0, '0, '0));
		send_op(make_item(xs128_pkg::OP_LOAD, '0, 32'h8000_0000, '0, '0, '0));
		send_op(make_item(xs128_pkg::OP_NEXT32, '0, '0, '0, '0, '0));
		send_op(make_item(3'd5, '1, '1, '1, '1, '1));
		send_op(make_item(3'd6, {$urandom, $urandom}, $urandom, $urandom, $urandom,
			$urandom));
		send_op(make_item(3'd7, '1, '1, '1, '1, '1));
		send_op(make_item(xs128_pkg::OP_SEED, {$urandom, $urandom}, '0, '0, '0, '0));
		send_op(make_item(xs128_pkg::OP_NEXT64, '0, '0, '0, '0, '0));

		// random part with a stretch free of stalls and one full drain
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			quiet = (i >= 150 && i < 250);
			if (i == 350)
				wait_for_drain();
			send_op(random_item());
		end
		quiet = 1'b0;

		// let everything drain
		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("** xorshift128_random_generator_core: PASSED **");
		else
			$display("** xorshift128_random_generator_core: FAILED **");
		$finish;
	end

endmodule
